// File: rtl/core/pdtf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdtf_pkg
// Shared types, sizes and filter coefficients for the 2/5 polyphase
// row resampler.
// ----------------------------------------------------------------------------
package pdtf_pkg;

    // Filter geometry
    localparam int TAP_HALF       = 3;
    localparam int NTAPS          = 2 * TAP_HALF + 1;
    localparam int SAMPLE_W       = 16;
    localparam int COEF_W         = 16;
    localparam int COEF_FRAC_BITS = 15;
    localparam int PROD_W         = SAMPLE_W + COEF_W;
    localparam int ACC_W          = PROD_W + $clog2(NTAPS);
    localparam int WARM_W         = $clog2(NTAPS + 1);

    // Output grid: two results out of every DECIM centre positions
    localparam int DECIM   = 5;
    localparam int PHASE_W = $clog2(DECIM);
    localparam logic [PHASE_W-1:0] POS_ON_GRID = PHASE_W'(0);
    localparam logic [PHASE_W-1:0] POS_HALF    = PHASE_W'(2);
    localparam logic [PHASE_W-1:0] POS_LAST    = PHASE_W'(DECIM - 1);

    // Result phase codes
    localparam logic OUT_ON_GRID = 1'b0;
    localparam logic OUT_HALF    = 1'b1;

    // Saturation limits of a result sample
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(1 << (SAMPLE_W - 1));
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (COEF_FRAC_BITS - 1));

    typedef logic signed [SAMPLE_W-1:0]     sample_t;
    typedef logic signed [COEF_W-1:0]       coef_t;
    typedef logic signed [PROD_W-1:0]       prod_t;
    typedef logic [NTAPS-1:0][SAMPLE_W-1:0] taps_t;

    // Window stage status handed to the multiply-accumulate side
    typedef struct packed {
        logic valid;
        logic phase;
    } win_ctrl_t;

    // Q1.15 taps, sinc * Hann, normalised to unit gain; index 0 meets the
    // oldest sample of the window.
    localparam coef_t COEF_EVEN [NTAPS] = '{
        -16'sd302, 16'sd1549, 16'sd8534, 16'sd13205, 16'sd8534, 16'sd1549, -16'sd302
    };
    localparam coef_t COEF_HALF [NTAPS] = '{
        -16'sd109, 16'sd2, 16'sd4595, 16'sd11841, 16'sd11841, 16'sd4595, 16'sd2
    };

endpackage

// File: rtl/core/polyphase_decimator_two_fifths.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyphase_decimator_two_fifths
// Resamples an image row by 2/5 with a 7-tap polyphase windowed-sinc filter.
// ----------------------------------------------------------------------------
// One sample is taken every clock cycle while the result side keeps up. The
// delay-line register, the product register and the result register form a
// three-stage pipeline: a result reaches the master side once the sample
// completing its window has passed the product and result registers. Each row
// carries three border samples at each end and is marked by tuser on its
// first sample. Once seven samples of the row are in, every fifth centre
// position gives an on-grid result (phase 0) and the position two later a
// result placed half a sample on (phase 1); the others give nothing. Results
// are rounded and saturated to 16 bits. A stall on the result side only holds
// input back once all three registers are full.
module polyphase_decimator_two_fifths (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    input  logic        s_tuser,   // [0] row_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] value
    output logic        m_tuser    // [0] phase
);

    pdtf_pkg::win_ctrl_t win;
    pdtf_pkg::taps_t     taps;
    pdtf_pkg::sample_t   value;
    logic                mac_ready;

    pdtf_window u_window (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_sample    ($signed(s_tdata)),
        .in_row_start (s_tuser),
        .in_ready     (s_tready),
        .mac_ready    (mac_ready),
        .win          (win),
        .taps         (taps)
    );

    pdtf_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .win       (win),
        .taps      (taps),
        .ready     (mac_ready),
        .out_valid (m_tvalid),
        .out_value (value),
        .out_phase (m_tuser),
        .out_ready (m_tready)
    );

    assign m_tdata = value;

    // First sample of a row never completes a window
    a_row_start_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser) |=> !win.valid)
        else $error("result flagged on first sample of a row");

    // The sample after a half-sample result falls between grid positions
    a_half_then_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (win.valid && win.phase == pdtf_pkg::OUT_HALF && s_tvalid && s_tready && !s_tuser)
        |=> !win.valid)
        else $error("result flagged right after a half-sample result");

    // The product stage only blocks when the result register is occupied
    a_stall_needs_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !mac_ready |-> m_tvalid)
        else $error("product stage stalled with empty result register");

    // Input is only held back while a result is pending downstream
    a_backpressure_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (win.valid && m_tvalid))
        else $error("input stalled with no pending result");

endmodule

// File: rtl/core/pdtf_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdtf_window
// Sample delay line with row warm-up and output-position tracking. Flags
// which accepted samples complete a window that produces a result.
// ----------------------------------------------------------------------------
module pdtf_window (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  pdtf_pkg::sample_t    in_sample,
    input  logic                 in_row_start,
    output logic                 in_ready,
    input  logic                 mac_ready,
    output pdtf_pkg::win_ctrl_t  win,
    output pdtf_pkg::taps_t      taps
);

    pdtf_pkg::taps_t                     line_reg;
    logic [pdtf_pkg::WARM_W-1:0]         warm_reg, warm_next;
    logic [pdtf_pkg::PHASE_W-1:0]        pos_reg, pos_next;
    logic                                valid_reg, valid_next;
    logic                                phase_reg, phase_next;

    logic [pdtf_pkg::WARM_W-1:0]         warm_base;
    logic [pdtf_pkg::PHASE_W-1:0]        pos_base;
    logic                                line_full;
    logic                                accept;

    assign in_ready = !valid_reg || mac_ready;
    assign accept   = in_valid && in_ready;

    // Row start restarts warm-up and the output grid before the sample enters
    always_comb begin
        warm_base = in_row_start ? '0 : warm_reg;
        pos_base  = in_row_start ? '0 : pos_reg;
        if (warm_base < pdtf_pkg::WARM_W'(pdtf_pkg::NTAPS)) begin
            warm_next = warm_base + 1'b1;
        end else begin
            warm_next = warm_base;
        end
        line_full = (warm_next == pdtf_pkg::WARM_W'(pdtf_pkg::NTAPS));
        if (!line_full) begin
            pos_next = pos_base;
        end else if (pos_base == pdtf_pkg::POS_LAST) begin
            pos_next = '0;
        end else begin
            pos_next = pos_base + 1'b1;
        end
        valid_next = line_full
                     && (pos_base == pdtf_pkg::POS_ON_GRID || pos_base == pdtf_pkg::POS_HALF);
        phase_next = (pos_base == pdtf_pkg::POS_HALF) ? pdtf_pkg::OUT_HALF
                                                      : pdtf_pkg::OUT_ON_GRID;
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            warm_reg  <= '0;
            pos_reg   <= '0;
            valid_reg <= 1'b0;
            phase_reg <= pdtf_pkg::OUT_ON_GRID;
        end else if (accept) begin
            warm_reg  <= warm_next;
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end else if (mac_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // Delay line, oldest sample at index 0; held while a result waits
    always_ff @(posedge aclk) begin
        if (accept) begin
            line_reg <= {in_sample, line_reg[pdtf_pkg::NTAPS-1:1]};
        end
    end

    assign win.valid = valid_reg;
    assign win.phase = phase_reg;
    assign taps      = line_reg;

endmodule

// File: rtl/core/pdtf_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdtf_mac
// Constant-coefficient products, then sum, round and saturate into the
// result register.
// ----------------------------------------------------------------------------
module pdtf_mac (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pdtf_pkg::win_ctrl_t  win,
    input  pdtf_pkg::taps_t      taps,
    output logic                 ready,
    output logic                 out_valid,
    output pdtf_pkg::sample_t    out_value,
    output logic                 out_phase,
    input  logic                 out_ready
);

    pdtf_pkg::prod_t                   prod_reg [pdtf_pkg::NTAPS];
    pdtf_pkg::prod_t                   prod_next [pdtf_pkg::NTAPS];
    logic                              prod_valid_reg;
    logic                              prod_phase_reg;

    logic                              res_valid_reg;
    pdtf_pkg::sample_t                 res_value_reg, res_value_next;
    logic                              res_phase_reg;

    logic                              res_ready;
    logic signed [pdtf_pkg::ACC_W-1:0] acc_sum;
    logic signed [pdtf_pkg::ACC_W-1:0] acc_shift;

    assign res_ready = !res_valid_reg || out_ready;
    assign ready     = !prod_valid_reg || res_ready;

    // Per-tap products, coefficient set picked by the output phase
    always_comb begin
        for (int j = 0; j < pdtf_pkg::NTAPS; j++) begin
            if (win.phase == pdtf_pkg::OUT_HALF) begin
                prod_next[j] = $signed(taps[j]) * pdtf_pkg::COEF_HALF[j];
            end else begin
                prod_next[j] = $signed(taps[j]) * pdtf_pkg::COEF_EVEN[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else if (ready) begin
            prod_valid_reg <= win.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready && win.valid) begin
            prod_reg       <= prod_next;
            prod_phase_reg <= win.phase;
        end
    end

    // Sum, round half up (floor shift), saturate
    always_comb begin
        acc_sum = pdtf_pkg::ROUND_HALF;
        for (int j = 0; j < pdtf_pkg::NTAPS; j++) begin
            acc_sum = acc_sum + pdtf_pkg::ACC_W'(prod_reg[j]);
        end
        acc_shift = acc_sum >>> pdtf_pkg::COEF_FRAC_BITS;
        if (acc_shift > pdtf_pkg::SAT_HI) begin
            res_value_next = pdtf_pkg::SAMPLE_W'(pdtf_pkg::SAT_HI);
        end else if (acc_shift < pdtf_pkg::SAT_LO) begin
            res_value_next = pdtf_pkg::SAMPLE_W'(pdtf_pkg::SAT_LO);
        end else begin
            res_value_next = acc_shift[pdtf_pkg::SAMPLE_W-1:0];
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (res_ready) begin
            res_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && prod_valid_reg) begin
            res_value_reg <= res_value_next;
            res_phase_reg <= prod_phase_reg;
        end
    end

    assign out_valid = res_valid_reg;
    assign out_value = res_value_reg;
    assign out_phase = res_phase_reg;

endmodule

// File: sim/resample_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resample_checker
// Watches both stream channels of the 2/5 row resampler, predicts each
// filtered pixel from the accepted samples, and compares every result
// transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module resample_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    input  logic        s_tuser,   // [0] row_start
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [15:0] value
    input  logic        m_tuser,   // [0] phase
    output int          mismatch_count,
    output int          results_pending
);

    // Q28 fixed-point constants for the tap design
    localparam longint Q_ONE     = 64'sd1 << 28;
    localparam longint TWO_PI_Q  = 64'sd1686629713;
    localparam longint PI_Q      = 64'sd843314857;
    localparam longint HALF_PI_Q = 64'sd421657428;

    typedef struct {
        pdtf_pkg::sample_t value;
        logic              phase;
    } pixel_t;

    longint            tap_even [pdtf_pkg::NTAPS];
    longint            tap_half [pdtf_pkg::NTAPS];
    pdtf_pkg::sample_t window [pdtf_pkg::NTAPS];        // [0] oldest
    int                row_fill;
    logic [pdtf_pkg::PHASE_W-1:0] centre_pos;
    pixel_t            pixel_q [$];

    // Range-reduced Taylor sine, Q28 in and out
    function automatic longint sine_q28(input longint arg);
        longint x, x2, term, acc;
        bit     neg;
        int     n;
        neg = 1'b0;
        x = arg % TWO_PI_Q;
        if (x >= PI_Q) begin
            x -= PI_Q;
            neg = 1'b1;
        end
        if (x > HALF_PI_Q) x = PI_Q - x;
        x2 = (x * x) / Q_ONE;
        term = x;
        acc = x;
        for (n = 1; n <= 10; n++) begin
            term = (term * x2) / Q_ONE / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) acc -= term;
            else acc += term;
        end
        return neg ? -acc : acc;
    endfunction

    // sinc * Hann weight at offset dbl_off/2, Q28
    function automatic longint window_weight(input longint dbl_off);
        longint sn, hn, a, c, d;
        if (dbl_off == 0) begin
            sn = (Q_ONE * 2 + 2) / 5;
        end else begin
            a = (dbl_off * 628 * Q_ONE + 500) / 1000;
            sn = (sine_q28(a) * Q_ONE * 2) / (5 * a);
        end
        d = 200 * longint'(pdtf_pkg::TAP_HALF + 1);
        a = (dbl_off * 314 * Q_ONE + d / 2) / d;
        c = sine_q28(a + HALF_PI_Q);
        hn = (Q_ONE + c) / 2;
        if (hn < 0) hn = 0;
        return (sn * hn) / Q_ONE;
    endfunction

    // Unit-gain tap set, rounded half away from zero
    function automatic void design_taps(output longint taps [pdtf_pkg::NTAPS],
                                        input bit half_step);
        longint w [pdtf_pkg::NTAPS];
        longint gain, m, num, mag, q;
        int     j;
        gain = 0;
        for (j = 0; j < pdtf_pkg::NTAPS; j++) begin
            m = 2 * longint'(j - pdtf_pkg::TAP_HALF) - (half_step ? 1 : 0);
            if (m < 0) m = -m;
            w[j] = window_weight(m);
            gain += w[j];
        end
        for (j = 0; j < pdtf_pkg::NTAPS; j++) begin
            if (gain > 0) begin
                num = w[j] * (64'sd1 << pdtf_pkg::COEF_FRAC_BITS);
                mag = (num < 0) ? -num : num;
                q = (mag + gain / 2) / gain;
                taps[j] = (num < 0) ? -q : q;
            end else begin
                taps[j] = 0;
            end
        end
    endfunction

    initial begin
        design_taps(tap_even, 1'b0);
        design_taps(tap_half, 1'b1);
    end

    // Multiply-accumulate over the window, floor after rounding offset, clip
    function automatic pdtf_pkg::sample_t filter_window(input longint taps [pdtf_pkg::NTAPS]);
        longint acc;
        int     j;
        acc = 0;
        for (j = 0; j < pdtf_pkg::NTAPS; j++) acc += longint'(window[j]) * taps[j];
        acc += 64'sd1 << (pdtf_pkg::COEF_FRAC_BITS - 1);
        acc = acc >>> pdtf_pkg::COEF_FRAC_BITS;
        if (acc > 32767) acc = 32767;
        if (acc < -32768) acc = -32768;
        return pdtf_pkg::sample_t'(acc);
    endfunction

    // One accepted sample: shift it in and queue any pixel it yields
    function automatic void take_sample(input pdtf_pkg::sample_t smp, input logic row_start);
        pixel_t px;
        logic [pdtf_pkg::PHASE_W-1:0] pos;
        int j;
        if (row_start) begin
            row_fill = 0;
            centre_pos = pdtf_pkg::POS_ON_GRID;
        end
        for (j = 0; j < pdtf_pkg::NTAPS - 1; j++) window[j] = window[j + 1];
        window[pdtf_pkg::NTAPS - 1] = smp;
        if (row_fill < pdtf_pkg::NTAPS) row_fill++;
        if (row_fill < pdtf_pkg::NTAPS) return;
        pos = centre_pos;
        centre_pos = (centre_pos == pdtf_pkg::POS_LAST) ? pdtf_pkg::POS_ON_GRID
                                                        : centre_pos + 1'b1;
        if (pos == pdtf_pkg::POS_ON_GRID) begin
            px.value = filter_window(tap_even);
            px.phase = pdtf_pkg::OUT_ON_GRID;
            pixel_q.push_back(px);
        end else if (pos == pdtf_pkg::POS_HALF) begin
            px.value = filter_window(tap_half);
            px.phase = pdtf_pkg::OUT_HALF;
            pixel_q.push_back(px);
        end
    endfunction

    // Predict on input transactions, compare on result transactions
    always @(posedge aclk) begin : watch
        pixel_t want;
        int j;
        if (!aresetn) begin
            for (j = 0; j < pdtf_pkg::NTAPS; j++) window[j] = '0;
            row_fill = 0;
            centre_pos = pdtf_pkg::POS_ON_GRID;
            pixel_q.delete();
        end else begin
            if (s_tvalid && s_tready) take_sample(pdtf_pkg::sample_t'(s_tdata), s_tuser);
            if (m_tvalid && m_tready) begin
                if (pixel_q.size() == 0) begin
                    $error("result with nothing expected: value %0d phase %0d",
                           $signed(m_tdata), m_tuser);
                    mismatch_count++;
                end else begin
                    want = pixel_q.pop_front();
                    if (m_tdata !== want.value) begin
                        $error("value: expected %0d, actual %0d",
                               want.value, $signed(m_tdata));
                        mismatch_count++;
                    end
                    if (m_tuser !== want.phase) begin
                        $error("phase: expected %0d, actual %0d", want.phase, m_tuser);
                        mismatch_count++;
                    end
                end
            end
        end
        results_pending = pixel_q.size();
    end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives image rows into the 2/5 polyphase resampler with random gaps on
// both channels; a separate checker predicts and compares every pixel.
// ----------------------------------------------------------------------------
module testbench;

    localparam pdtf_pkg::sample_t SMP_MAX = 16'sh7FFF;
    localparam pdtf_pkg::sample_t SMP_MIN = 16'sh8000;
    localparam int      BORDER  = pdtf_pkg::TAP_HALF;
    localparam int      ITEM_TARGET = 1775;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;    // [15:0] sample
    logic        s_tuser = 1'b0;  // [0] row_start
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [15:0] value
    logic        m_tuser;         // [0] phase

    int mismatch_count;
    int results_pending;
    int samples_sent = 0;
    int send_gap_pct = 12;
    int recv_stall_pct = 55;

    polyphase_decimator_two_fifths dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    resample_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Result side back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Mostly full-range pixels, with the odd extreme
    function automatic pdtf_pkg::sample_t pick_pixel();
        case ($urandom_range(0, 9))
            0: return SMP_MAX;
            1: return SMP_MIN;
            2: return pdtf_pkg::sample_t'($urandom_range(0, 1) ? 0 : -1);
            default: return pdtf_pkg::sample_t'($urandom_range(0, 65535));
        endcase
    endfunction

    // One input transaction; acceptance judged from tready before the edge
    task automatic send_pixel(input pdtf_pkg::sample_t smp, input logic row_start);
        bit taken;
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= row_start;
        do begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end while (!taken);
        samples_sent++;
    endtask

    // Hold the input off until every predicted pixel has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (results_pending != 0);
        @(posedge aclk);
    endtask

    // Bordered row of random content
    task automatic send_row(input int body_len);
        int i;
        for (i = 0; i < body_len + 2 * BORDER; i++) send_pixel(pick_pixel(), i == 0);
    endtask

    initial begin : stimulus
        int  i, n;
        bit  drained;
        drained = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Samples before any row marker behave as a row begun at reset
        for (i = 0; i < pdtf_pkg::NTAPS; i++) send_pixel(i[0] ? SMP_MIN : SMP_MAX, 1'b0);
        // Extremes lined up against the tap signs: clip high on the on-grid phase
        for (i = 0; i < 10; i++)
            send_pixel((i % pdtf_pkg::NTAPS == 0 || i % pdtf_pkg::NTAPS == pdtf_pkg::NTAPS - 1)
                       ? SMP_MIN : SMP_MAX, i == 0);
        // Row cut short by the next row start, too short to warm up
        for (i = 0; i < 3; i++) send_pixel(pick_pixel(), i == 0);
        // Inverted pattern: clip low
        for (i = 0; i < pdtf_pkg::NTAPS; i++)
            send_pixel((i % pdtf_pkg::NTAPS == 0 || i % pdtf_pkg::NTAPS == pdtf_pkg::NTAPS - 1)
                       ? SMP_MAX : SMP_MIN, i == 0);
        drain_results();

        // Random rows, with broken rows and loose noise mixed in
        while (samples_sent < ITEM_TARGET) begin
            if (samples_sent >= 1200) begin
                send_gap_pct = 0;
                recv_stall_pct = 0;
            end else if (samples_sent >= 600) begin
                send_gap_pct = 55;
                recv_stall_pct = 12;
            end
            if (!drained && samples_sent >= 900) begin
                drain_results();
                drained = 1'b1;
            end
            case ($urandom_range(0, 9))
                0: begin
                    // Short row that may end before warm-up completes
                    n = $urandom_range(1, pdtf_pkg::NTAPS + 2);
                    for (i = 0; i < n; i++) send_pixel(pick_pixel(), i == 0);
                end
                1: begin
                    // Loose samples with random row markers
                    n = $urandom_range(1, 6);
                    for (i = 0; i < n; i++)
                        send_pixel(pick_pixel(), logic'($urandom_range(0, 1)));
                end
                2: send_row($urandom_range(25, 60));
                default: send_row($urandom_range(1, 24));
            endcase
        end

        s_tvalid <= 1'b0;
        do @(negedge aclk); while (results_pending != 0);
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
